// ----- design/ffha_pkg.sv -----
// ----------------------------------------------------------------------------
// First-fit heap allocator package
// Shared sizes, the chunk table entry layout, status codes and the command
// and status structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int MAX_CHUNKS   = 64;
    localparam int PAGE_SHIFT   = 12;
    localparam int PAGE_BYTES   = 1 << PAGE_SHIFT;
    localparam int HEADER_BYTES = 16;

    localparam int IDX_W    = $clog2(MAX_CHUNKS);
    localparam int CNT_W    = $clog2(MAX_CHUNKS + 1);
    localparam int ADDR_W   = 32;
    localparam int LEN_W    = 25;
    localparam int REQ_W    = 24;
    localparam int PAGES_W  = 13;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNKNOWN = 2'd2;

    localparam logic CMD_FREE = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [LEN_W-1:0]  len;
        logic              used;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Source of the word written into the chunk table.
    typedef enum logic [2:0] {
        WS_COPY,
        WS_SPLIT_NEW,
        WS_ALLOC_CUR,
        WS_APPEND,
        WS_MERGED
    } t_wsel;

    // How the datapath closes out an item.
    typedef enum logic [2:0] {
        FIN_ALLOC_HIT,
        FIN_APPEND,
        FIN_UNKNOWN,
        FIN_FREE,
        FIN_RELEASE
    } t_fin;

    // Datapath step for the current cycle.
    typedef enum logic [3:0] {
        DP_NONE,
        DP_LOAD,
        DP_SCAN,
        DP_M1,
        DP_M2,
        DP_M3,
        DP_M4,
        DP_EVAL1,
        DP_EVAL2,
        DP_REL
    } t_dp_op;

    typedef struct packed {
        t_dp_op           op;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        t_wsel            wr_sel;
        logic             finish;
        t_fin             fin;
        logic             has_next;
        logic             has_prev;
        logic             table_empty;
        logic             table_full;
    } t_dp_cmd;

    typedef struct packed {
        logic is_free;
        logic hit;
        logic split;
        logic append_ok;
        logic merge_next;
        logic merge_prev;
    } t_dp_stat;

endpackage

// ----- design/ffha_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/ffha_dp.sv -----
// ----------------------------------------------------------------------------
// Heap allocator datapath
// Holds the chunk table memory, the heap base and end, the item being worked
// on and the result registers; does the compares and sums for each step.
// ----------------------------------------------------------------------------
module ffha_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ffha_pkg::ADDR_W-1:0]         i_cfg_heap_base,
    input  logic                                i_cmd,
    input  logic [ffha_pkg::REQ_W-1:0]          i_request_size,
    input  logic [ffha_pkg::ADDR_W-1:0]         i_user_address,
    input  ffha_pkg::t_dp_cmd                   i_ctl,
    output ffha_pkg::t_dp_stat                  o_stat,
    output logic [ffha_pkg::ADDR_W-1:0]         o_result_address,
    output logic [ffha_pkg::STATUS_W-1:0]       o_status,
    output logic [ffha_pkg::ADDR_W-1:0]         o_heap_end,
    output logic [ffha_pkg::PAGES_W-1:0]        o_pages_added,
    output logic [ffha_pkg::PAGES_W-1:0]        o_pages_released
);

    localparam int AW = ffha_pkg::ADDR_W;
    localparam int LW = ffha_pkg::LEN_W;
    localparam int PS = ffha_pkg::PAGE_SHIFT;
    localparam int PGW = AW + 2 - PS;
    localparam int RLW = AW - PS;

    // Table memory.
    ffha_pkg::t_entry w_rdata;
    ffha_pkg::t_entry w_wdata;
    logic             w_we;

    ffha_ram #(
        .WIDTH(ffha_pkg::ENTRY_W),
        .DEPTH(ffha_pkg::MAX_CHUNKS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_ctl.wr_addr),
        .i_wdata (w_wdata),
        .i_re    (i_ctl.rd_en),
        .i_raddr (i_ctl.rd_addr),
        .o_rdata (w_rdata)
    );

    // Heap state.
    logic [AW-1:0] r_heap_base;
    logic [AW-1:0] r_mapped;
    logic [AW-1:0] n_mapped;

    // Item and working registers.
    logic                  r_cmd;
    logic [LW-1:0]         r_need;
    logic [AW-1:0]         r_ua;
    ffha_pkg::t_entry      r_cur;
    ffha_pkg::t_entry      r_prev;
    logic [AW:0]           r_abase;
    logic [AW+1:0]         r_end;
    logic [PGW-1:0]        r_pages;
    logic [AW+2:0]         r_newend;
    logic                  r_mn;
    logic                  r_mp;
    logic [LW-1:0]         r_lc;
    logic [LW-1:0]         r_lj;
    logic [AW-1:0]         r_js;
    logic [RLW-1:0]        r_reln;

    // Results.
    logic [AW-1:0]                   r_res;
    logic [ffha_pkg::STATUS_W-1:0]   r_status;
    logic [ffha_pkg::PAGES_W-1:0]    r_added;
    logic [ffha_pkg::PAGES_W-1:0]    r_released;

    // Scan compares.
    logic          w_fit;
    logic          w_match;
    logic          w_hit;
    logic [LW-1:0] w_rest;
    logic          w_split;
    logic          w_append_ok;

    // Sums for the steps.
    logic [LW:0]   w_sum_next;
    logic [LW:0]   w_sum_prev;
    logic [AW+1:0] w_over;
    logic [AW+1:0] w_over_up;
    logic [AW-1:0] w_rdiff;

    assign w_fit   = w_rdata.len >= r_need;
    assign w_match = ({1'b0, w_rdata.start} + (AW+1)'(ffha_pkg::HEADER_BYTES))
                     == {1'b0, r_ua};
    assign w_hit   = (r_cmd == ffha_pkg::CMD_FREE) ? (w_rdata.used && w_match)
                                                   : (!w_rdata.used && w_fit);
    assign w_rest  = r_cur.len - r_need;
    assign w_split = (w_rest > LW'(ffha_pkg::HEADER_BYTES)) && !i_ctl.table_full;
    assign w_append_ok = !i_ctl.table_full && (r_end[AW+1:AW] == 2'b00)
                         && (r_newend[AW+2:AW] == 3'b000);

    assign w_sum_next = {1'b0, r_cur.len} + {1'b0, w_rdata.len};
    assign w_sum_prev = {1'b0, r_prev.len} + {1'b0, r_lc};
    assign w_over     = r_end - {2'b00, r_mapped};
    assign w_over_up  = w_over + (AW+2)'(ffha_pkg::PAGE_BYTES - 1);
    assign w_rdiff    = r_mapped - r_js;

    assign o_stat.is_free    = (r_cmd == ffha_pkg::CMD_FREE);
    assign o_stat.hit        = w_hit;
    assign o_stat.split      = w_split;
    assign o_stat.append_ok  = w_append_ok;
    assign o_stat.merge_next = r_mn;
    assign o_stat.merge_prev = r_mp;

    // Write data selection.
    always_comb begin
        w_wdata = w_rdata;
        case (i_ctl.wr_sel)
            ffha_pkg::WS_COPY: begin
                w_wdata = w_rdata;
            end
            ffha_pkg::WS_SPLIT_NEW: begin
                w_wdata.start = r_cur.start + AW'(r_need);
                w_wdata.len   = w_rest;
                w_wdata.used  = 1'b0;
            end
            ffha_pkg::WS_ALLOC_CUR: begin
                w_wdata.start = r_cur.start;
                w_wdata.len   = w_split ? r_need : r_cur.len;
                w_wdata.used  = 1'b1;
            end
            ffha_pkg::WS_APPEND: begin
                w_wdata.start = r_abase[AW-1:0];
                w_wdata.len   = r_need;
                w_wdata.used  = 1'b1;
            end
            ffha_pkg::WS_MERGED: begin
                w_wdata.start = r_js;
                w_wdata.len   = r_lj;
                w_wdata.used  = 1'b0;
            end
            default: begin
                w_wdata = w_rdata;
            end
        endcase
    end

    // An append is written only when it succeeds.
    assign w_we = i_ctl.wr_en && ((i_ctl.wr_sel != ffha_pkg::WS_APPEND) || w_append_ok);

    // Heap end after the closing step.
    always_comb begin
        n_mapped = r_mapped;
        if (i_ctl.finish) begin
            case (i_ctl.fin)
                ffha_pkg::FIN_APPEND: begin
                    if (w_append_ok) begin
                        n_mapped = r_newend[AW-1:0];
                    end
                end
                ffha_pkg::FIN_RELEASE: begin
                    n_mapped = r_mapped - {r_reln, PS'(0)};
                end
                default: begin
                    n_mapped = r_mapped;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base <= '0;
            r_mapped    <= '0;
        end else if (i_cfg_we) begin
            r_heap_base <= i_cfg_heap_base;
            r_mapped    <= i_cfg_heap_base;
        end else begin
            r_mapped <= n_mapped;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            ffha_pkg::DP_LOAD: begin
                r_cmd  <= i_cmd;
                r_need <= LW'(i_request_size) + LW'(ffha_pkg::HEADER_BYTES);
                r_ua   <= i_user_address;
            end
            ffha_pkg::DP_SCAN: begin
                if (w_hit) begin
                    r_cur <= w_rdata;
                end else begin
                    r_prev <= w_rdata;
                end
            end
            ffha_pkg::DP_M1: begin
                r_abase <= i_ctl.table_empty ? {1'b0, r_heap_base}
                         : ({1'b0, r_prev.start} + (AW+1)'(r_prev.len));
            end
            ffha_pkg::DP_M2: begin
                r_end <= {1'b0, r_abase} + (AW+2)'(r_need);
            end
            ffha_pkg::DP_M3: begin
                r_pages <= (r_end > {2'b00, r_mapped}) ? w_over_up[AW+1:PS] : '0;
            end
            ffha_pkg::DP_M4: begin
                r_newend <= {3'b000, r_mapped} + (AW+3)'({r_pages, PS'(0)});
            end
            ffha_pkg::DP_EVAL1: begin
                r_mn <= i_ctl.has_next && !w_rdata.used && !w_sum_next[LW];
                r_lc <= (i_ctl.has_next && !w_rdata.used && !w_sum_next[LW])
                        ? w_sum_next[LW-1:0] : r_cur.len;
            end
            ffha_pkg::DP_EVAL2: begin
                r_mp <= i_ctl.has_prev && !r_prev.used && !w_sum_prev[LW];
                if (i_ctl.has_prev && !r_prev.used && !w_sum_prev[LW]) begin
                    r_lj <= w_sum_prev[LW-1:0];
                    r_js <= r_prev.start;
                end else begin
                    r_lj <= r_lc;
                    r_js <= r_cur.start;
                end
            end
            ffha_pkg::DP_REL: begin
                r_reln <= (r_mapped >= r_js) ? w_rdiff[AW-1:PS] : '0;
            end
            default: begin
            end
        endcase

        if (i_ctl.finish) begin
            r_res      <= '0;
            r_status   <= ffha_pkg::STATUS_OK;
            r_added    <= '0;
            r_released <= '0;
            case (i_ctl.fin)
                ffha_pkg::FIN_ALLOC_HIT: begin
                    r_res <= r_cur.start + AW'(ffha_pkg::HEADER_BYTES);
                end
                ffha_pkg::FIN_APPEND: begin
                    if (w_append_ok) begin
                        r_res   <= r_abase[AW-1:0] + AW'(ffha_pkg::HEADER_BYTES);
                        r_added <= r_pages[ffha_pkg::PAGES_W-1:0];
                    end else begin
                        r_status <= ffha_pkg::STATUS_FULL;
                    end
                end
                ffha_pkg::FIN_UNKNOWN: begin
                    r_status <= ffha_pkg::STATUS_UNKNOWN;
                end
                ffha_pkg::FIN_RELEASE: begin
                    r_released <= r_reln[ffha_pkg::PAGES_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_result_address = r_res;
    assign o_status         = r_status;
    assign o_heap_end       = r_mapped;
    assign o_pages_added    = r_added;
    assign o_pages_released = r_released;

endmodule

// ----- design/ffha_ctrl.sv -----
// ----------------------------------------------------------------------------
// Heap allocator controller
// Walks the chunk table, sequences splits, appends, merges and table shifts,
// and keeps the chunk count.
// ----------------------------------------------------------------------------
module ffha_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_cfg_we,
    input  ffha_pkg::t_dp_stat  i_stat,
    output ffha_pkg::t_dp_cmd   o_ctl,
    output logic                o_busy,
    output logic                o_done
);

    localparam int CW = ffha_pkg::CNT_W;
    localparam int IW = ffha_pkg::IDX_W;

    typedef enum logic [4:0] {
        S_IDLE,
        S_EMPTY,
        S_SCAN,
        S_AL_HIT,
        S_AL_SHUP,
        S_AL_WNEW,
        S_AL_WCUR,
        S_AL_M1,
        S_AL_M2,
        S_AL_M3,
        S_AL_M4,
        S_AL_M5,
        S_FR_EVAL1,
        S_FR_EVAL2,
        S_FR_ACT,
        S_FR_REL,
        S_FR_FIN,
        S_SHDN
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_k, n_k;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_lim, n_lim;
    logic [1:0]    r_d, n_d;
    logic          r_done, n_done;

    logic [CW-1:0] w_k_inc;
    logic [CW-1:0] w_idx_inc;
    logic [CW-1:0] w_last;
    logic [1:0]    w_d;
    logic [CW-1:0] w_cnew;
    logic [CW-1:0] w_j;
    logic [CW-1:0] w_src;

    assign w_k_inc   = r_k + CW'(1);
    assign w_idx_inc = r_idx + CW'(1);
    assign w_last    = r_count - CW'(1);
    assign w_d       = {1'b0, i_stat.merge_next} + {1'b0, i_stat.merge_prev};
    assign w_cnew    = r_count - CW'(w_d);
    assign w_j       = r_idx - CW'(i_stat.merge_prev);
    assign w_src     = w_idx_inc + CW'(i_stat.merge_next);

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_k     = r_k;
        n_idx   = r_idx;
        n_lim   = r_lim;
        n_d     = r_d;
        n_done  = 1'b0;

        o_ctl.op          = ffha_pkg::DP_NONE;
        o_ctl.rd_en       = 1'b0;
        o_ctl.rd_addr     = '0;
        o_ctl.wr_en       = 1'b0;
        o_ctl.wr_addr     = '0;
        o_ctl.wr_sel      = ffha_pkg::WS_COPY;
        o_ctl.finish      = 1'b0;
        o_ctl.fin         = ffha_pkg::FIN_FREE;
        o_ctl.has_next    = w_idx_inc < r_count;
        o_ctl.has_prev    = r_idx != '0;
        o_ctl.table_empty = r_count == '0;
        o_ctl.table_full  = r_count == CW'(ffha_pkg::MAX_CHUNKS);

        case (r_state)
            S_IDLE: begin
                if (i_cfg_we) begin
                    n_count = '0;
                end else if (i_start) begin
                    o_ctl.op = ffha_pkg::DP_LOAD;
                    if (r_count == '0) begin
                        n_state = S_EMPTY;
                    end else begin
                        o_ctl.rd_en   = 1'b1;
                        o_ctl.rd_addr = '0;
                        n_k           = '0;
                        n_state       = S_SCAN;
                    end
                end
            end
            S_EMPTY: begin
                if (i_stat.is_free) begin
                    o_ctl.finish = 1'b1;
                    o_ctl.fin    = ffha_pkg::FIN_UNKNOWN;
                    n_done       = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_AL_M1;
                end
            end
            S_SCAN: begin
                // The next entry, if any, is fetched every cycle; on a free hit it is
                // the right-hand neighbor needed for merging.
                o_ctl.op      = ffha_pkg::DP_SCAN;
                o_ctl.rd_en   = w_k_inc < r_count;
                o_ctl.rd_addr = w_k_inc[IW-1:0];
                if (i_stat.hit) begin
                    n_idx   = r_k;
                    n_state = i_stat.is_free ? S_FR_EVAL1 : S_AL_HIT;
                end else if (w_k_inc < r_count) begin
                    n_k = w_k_inc;
                end else if (i_stat.is_free) begin
                    o_ctl.finish = 1'b1;
                    o_ctl.fin    = ffha_pkg::FIN_UNKNOWN;
                    n_done       = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_AL_M1;
                end
            end
            S_AL_HIT: begin
                if (i_stat.split) begin
                    if (w_last > r_idx) begin
                        o_ctl.rd_en   = 1'b1;
                        o_ctl.rd_addr = w_last[IW-1:0];
                        n_k           = w_last;
                        n_state       = S_AL_SHUP;
                    end else begin
                        n_state = S_AL_WNEW;
                    end
                end else begin
                    o_ctl.wr_en   = 1'b1;
                    o_ctl.wr_addr = r_idx[IW-1:0];
                    o_ctl.wr_sel  = ffha_pkg::WS_ALLOC_CUR;
                    o_ctl.finish  = 1'b1;
                    o_ctl.fin     = ffha_pkg::FIN_ALLOC_HIT;
                    n_done        = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_AL_SHUP: begin
                o_ctl.wr_en   = 1'b1;
                o_ctl.wr_addr = w_k_inc[IW-1:0];
                o_ctl.wr_sel  = ffha_pkg::WS_COPY;
                if (r_k > w_idx_inc) begin
                    o_ctl.rd_en   = 1'b1;
                    o_ctl.rd_addr = IW'(r_k - CW'(1));
                    n_k           = r_k - CW'(1);
                end else begin
                    n_state = S_AL_WNEW;
                end
            end
            S_AL_WNEW: begin
                o_ctl.wr_en   = 1'b1;
                o_ctl.wr_addr = w_idx_inc[IW-1:0];
                o_ctl.wr_sel  = ffha_pkg::WS_SPLIT_NEW;
                n_state       = S_AL_WCUR;
            end
            S_AL_WCUR: begin
                o_ctl.wr_en   = 1'b1;
                o_ctl.wr_addr = r_idx[IW-1:0];
                o_ctl.wr_sel  = ffha_pkg::WS_ALLOC_CUR;
                o_ctl.finish  = 1'b1;
                o_ctl.fin     = ffha_pkg::FIN_ALLOC_HIT;
                n_count       = r_count + CW'(1);
                n_done        = 1'b1;
                n_state       = S_IDLE;
            end
            S_AL_M1: begin
                o_ctl.op = ffha_pkg::DP_M1;
                n_state  = S_AL_M2;
            end
            S_AL_M2: begin
                o_ctl.op = ffha_pkg::DP_M2;
                n_state  = S_AL_M3;
            end
            S_AL_M3: begin
                o_ctl.op = ffha_pkg::DP_M3;
                n_state  = S_AL_M4;
            end
            S_AL_M4: begin
                o_ctl.op = ffha_pkg::DP_M4;
                n_state  = S_AL_M5;
            end
            S_AL_M5: begin
                o_ctl.wr_en   = 1'b1;
                o_ctl.wr_addr = r_count[IW-1:0];
                o_ctl.wr_sel  = ffha_pkg::WS_APPEND;
                o_ctl.finish  = 1'b1;
                o_ctl.fin     = ffha_pkg::FIN_APPEND;
                if (i_stat.append_ok) begin
                    n_count = r_count + CW'(1);
                end
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_FR_EVAL1: begin
                o_ctl.op = ffha_pkg::DP_EVAL1;
                n_state  = S_FR_EVAL2;
            end
            S_FR_EVAL2: begin
                o_ctl.op = ffha_pkg::DP_EVAL2;
                n_state  = S_FR_ACT;
            end
            S_FR_ACT: begin
                if ((w_j + CW'(1)) == w_cnew) begin
                    // The freed chunk ends the heap: drop it.
                    n_count = w_j;
                    n_state = S_FR_REL;
                end else begin
                    o_ctl.wr_en   = 1'b1;
                    o_ctl.wr_addr = w_j[IW-1:0];
                    o_ctl.wr_sel  = ffha_pkg::WS_MERGED;
                    n_count       = w_cnew;
                    if (w_d != 2'd0) begin
                        o_ctl.rd_en   = 1'b1;
                        o_ctl.rd_addr = w_src[IW-1:0];
                        n_k           = w_src;
                        n_lim         = r_count;
                        n_d           = w_d;
                        n_state       = S_SHDN;
                    end else begin
                        o_ctl.finish = 1'b1;
                        o_ctl.fin    = ffha_pkg::FIN_FREE;
                        n_done       = 1'b1;
                        n_state      = S_IDLE;
                    end
                end
            end
            S_SHDN: begin
                o_ctl.wr_en   = 1'b1;
                o_ctl.wr_addr = IW'(r_k - CW'(r_d));
                o_ctl.wr_sel  = ffha_pkg::WS_COPY;
                if (w_k_inc < r_lim) begin
                    o_ctl.rd_en   = 1'b1;
                    o_ctl.rd_addr = w_k_inc[IW-1:0];
                    n_k           = w_k_inc;
                end else begin
                    o_ctl.finish = 1'b1;
                    o_ctl.fin    = ffha_pkg::FIN_FREE;
                    n_done       = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_FR_REL: begin
                o_ctl.op = ffha_pkg::DP_REL;
                n_state  = S_FR_FIN;
            end
            S_FR_FIN: begin
                o_ctl.finish = 1'b1;
                o_ctl.fin    = ffha_pkg::FIN_RELEASE;
                n_done       = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_k     <= '0;
            r_idx   <= '0;
            r_lim   <= '0;
            r_d     <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_k     <= n_k;
            r_idx   <= n_idx;
            r_lim   <= n_lim;
            r_d     <= n_d;
            r_done  <= n_done;
        end
    end

    assign o_busy = r_state != S_IDLE;
    assign o_done = r_done;

endmodule

// ----- design/first_fit_heap_allocator_top.sv -----
// ----------------------------------------------------------------------------
// First-fit heap allocator
// Keeps an address-ordered table of heap chunks and serves allocate and free
// commands one at a time, reporting page growth and release.
// ----------------------------------------------------------------------------
// Issue a command by raising start while busy is low; the command fields are
// sampled in that cycle. Exactly one result beat follows: o_done is high for
// a single cycle with the result fields valid, and it cannot be held off, so
// the receiver must take it in that cycle. The chunk table sits in a memory
// with one read port, so the search visits one entry per clock cycle. An
// allocate that hits an entry marks it used; when the chunk is split, the
// entries above it first move up one at a time, then the new free entry and
// the current entry are written. An allocate that must extend the heap walks
// the whole table, then works out the append address and the pages it needs.
// A free that finds its entry checks both neighbors, then moves later entries
// down one at a time after a merge, or hands back pages when the freed chunk
// ends the heap. A new command may be started in the same cycle in which the
// previous result is shown.
// Writing heap_base empties the table and sets the heap end to that address;
// it is accepted only while busy and start are both low, so a command that is
// started in the same cycle goes first. After reset the table is empty and
// the heap base is zero.
module first_fit_heap_allocator_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    output logic                                o_done,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ffha_pkg::ADDR_W-1:0]         i_cfg_heap_base,
    input  logic                                i_cmd,
    input  logic [ffha_pkg::REQ_W-1:0]          i_request_size,
    input  logic [ffha_pkg::ADDR_W-1:0]         i_user_address,
    output logic [ffha_pkg::ADDR_W-1:0]         o_result_address,
    output logic [ffha_pkg::STATUS_W-1:0]       o_status,
    output logic [ffha_pkg::ADDR_W-1:0]         o_heap_end,
    output logic [ffha_pkg::PAGES_W-1:0]        o_pages_added,
    output logic [ffha_pkg::PAGES_W-1:0]        o_pages_released
);

    ffha_pkg::t_dp_cmd  w_ctl;
    ffha_pkg::t_dp_stat w_stat;
    logic               w_busy;
    logic               w_cfg_we;

    // Configuration is taken only between commands, and never in a cycle in
    // which a command is being started.
    assign o_cfg_ready = !w_busy && !start;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;
    assign busy        = w_busy;

    ffha_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cfg_we(w_cfg_we),
        .i_stat  (w_stat),
        .o_ctl   (w_ctl),
        .o_busy  (w_busy),
        .o_done  (o_done)
    );

    ffha_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (w_cfg_we),
        .i_cfg_heap_base  (i_cfg_heap_base),
        .i_cmd            (i_cmd),
        .i_request_size   (i_request_size),
        .i_user_address   (i_user_address),
        .i_ctl            (w_ctl),
        .o_stat           (w_stat),
        .o_result_address (o_result_address),
        .o_status         (o_status),
        .o_heap_end       (o_heap_end),
        .o_pages_added    (o_pages_added),
        .o_pages_released (o_pages_released)
    );

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// First-fit heap allocator testbench
// Drives allocate and free commands with random gaps and heap_base writes
// between phases. A scoreboard class models the chunk table and checks every
// result beat, field by field, against its own prediction.
// ----------------------------------------------------------------------------
class heap_scoreboard;

    localparam int ADDR_W       = ffha_pkg::ADDR_W;
    localparam int STATUS_W     = ffha_pkg::STATUS_W;
    localparam int PAGES_W      = ffha_pkg::PAGES_W;
    localparam int LEN_W        = ffha_pkg::LEN_W;
    localparam int REQ_W        = ffha_pkg::REQ_W;
    localparam int MAX_CHUNKS   = ffha_pkg::MAX_CHUNKS;
    localparam int HEADER_BYTES = ffha_pkg::HEADER_BYTES;
    localparam int PAGE_BYTES   = ffha_pkg::PAGE_BYTES;

    typedef struct {
        logic [ADDR_W-1:0]   addr;
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   heap_end;
        logic [PAGES_W-1:0]  added;
        logic [PAGES_W-1:0]  released;
    } t_outcome;

    t_outcome          pending[$];
    int                mismatches;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] mapped_end;
    logic [ADDR_W-1:0] chunk_at[MAX_CHUNKS];
    logic [LEN_W-1:0]  chunk_len[MAX_CHUNKS];
    logic              chunk_used[MAX_CHUNKS];
    int                chunks;

    function new();
        mismatches = 0;
        set_base('0);
    endfunction

    // A heap_base write empties the table.
    function void set_base(logic [ADDR_W-1:0] value);
        base       = value;
        mapped_end = value;
        chunks     = 0;
    endfunction

    function void drop_entry(int i);
        for (int k = i; k + 1 < chunks; k++) begin
            chunk_at[k]   = chunk_at[k + 1];
            chunk_len[k]  = chunk_len[k + 1];
            chunk_used[k] = chunk_used[k + 1];
        end
        chunks--;
    endfunction

    function void add_entry(int i, logic [ADDR_W-1:0] at, longint len, logic used);
        for (int k = chunks; k > i; k--) begin
            chunk_at[k]   = chunk_at[k - 1];
            chunk_len[k]  = chunk_len[k - 1];
            chunk_used[k] = chunk_used[k - 1];
        end
        chunk_at[i]   = at;
        chunk_len[i]  = len[LEN_W-1:0];
        chunk_used[i] = used;
        chunks++;
    endfunction

    // Returns a user address of a live chunk, or a random one if none is live.
    function logic [ADDR_W-1:0] live_address();
        int live[$];
        for (int i = 0; i < chunks; i++)
            if (chunk_used[i]) live.push_back(i);
        if (live.size() == 0) return $urandom;
        return chunk_at[live[$urandom_range(0, live.size() - 1)]] + HEADER_BYTES;
    endfunction

    // Predicts the result of one accepted command and queues it.
    function void note_command(logic cmd, logic [REQ_W-1:0] req, logic [ADDR_W-1:0] ua);
        t_outcome o;
        longint   need, rest, tail, fresh_end, new_end, pages, rel;
        bit       done;
        int       idx;
        o = '{default: '0};
        pages = 0;
        rel = 0;
        if (cmd != ffha_pkg::CMD_FREE) begin
            need = longint'(req) + HEADER_BYTES;
            done = 0;
            for (int i = 0; i < chunks && !done; i++) begin
                if (!chunk_used[i] && chunk_len[i] >= need) begin
                    rest = chunk_len[i] - need;
                    if (rest > HEADER_BYTES && chunks < MAX_CHUNKS) begin
                        add_entry(i + 1, chunk_at[i] + need[ADDR_W-1:0], rest, 1'b0);
                        chunk_len[i] = need[LEN_W-1:0];
                    end
                    chunk_used[i] = 1'b1;
                    o.addr = chunk_at[i] + HEADER_BYTES;
                    done = 1;
                end
            end
            if (!done) begin
                if (chunks >= MAX_CHUNKS) begin
                    o.status = ffha_pkg::STATUS_FULL;
                end else begin
                    tail = chunks ? longint'(chunk_at[chunks - 1]) + chunk_len[chunks - 1]
                                  : longint'(base);
                    fresh_end = tail + need;
                    new_end = mapped_end;
                    if (fresh_end > new_end) begin
                        pages = (fresh_end - new_end + PAGE_BYTES - 1) / PAGE_BYTES;
                        new_end += pages * PAGE_BYTES;
                    end
                    if (fresh_end > 64'hFFFF_FFFF || new_end > 64'hFFFF_FFFF) begin
                        o.status = ffha_pkg::STATUS_FULL;
                        pages = 0;
                    end else begin
                        add_entry(chunks, tail[ADDR_W-1:0], need, 1'b1);
                        mapped_end = new_end[ADDR_W-1:0];
                        o.addr = tail[ADDR_W-1:0] + HEADER_BYTES;
                    end
                end
            end
        end else begin
            idx = -1;
            for (int i = 0; i < chunks && idx < 0; i++)
                if (chunk_used[i] && longint'(chunk_at[i]) + HEADER_BYTES == longint'(ua))
                    idx = i;
            if (idx < 0) begin
                o.status = ffha_pkg::STATUS_UNKNOWN;
            end else begin
                chunk_used[idx] = 1'b0;
                // Neighbors merge only when the summed length still fits.
                if (idx + 1 < chunks && !chunk_used[idx + 1] &&
                    longint'(chunk_len[idx]) + chunk_len[idx + 1] < (64'd1 << LEN_W)) begin
                    chunk_len[idx] += chunk_len[idx + 1];
                    drop_entry(idx + 1);
                end
                if (idx > 0 && !chunk_used[idx - 1] &&
                    longint'(chunk_len[idx - 1]) + chunk_len[idx] < (64'd1 << LEN_W)) begin
                    chunk_len[idx - 1] += chunk_len[idx];
                    drop_entry(idx);
                    idx--;
                end
                // A free chunk at the tail is dropped and its pages handed back.
                if (idx + 1 == chunks) begin
                    tail = chunk_at[idx];
                    drop_entry(idx);
                    while (mapped_end >= PAGE_BYTES && mapped_end - PAGE_BYTES >= tail) begin
                        mapped_end -= PAGE_BYTES;
                        rel++;
                    end
                end
            end
        end
        o.heap_end = mapped_end;
        o.added    = pages[PAGES_W-1:0];
        o.released = rel[PAGES_W-1:0];
        pending.push_back(o);
    endfunction

    task report_mismatch(string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    task check_result(t_outcome got);
        t_outcome want;
        if (pending.size() == 0) begin
            report_mismatch("result beat with no command outstanding");
            return;
        end
        want = pending.pop_front();
        if (got.addr !== want.addr)
            report_mismatch($sformatf("address %h, want %h", got.addr, want.addr));
        if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.heap_end !== want.heap_end)
            report_mismatch($sformatf("heap end %h, want %h", got.heap_end, want.heap_end));
        if (got.added !== want.added)
            report_mismatch($sformatf("pages added %0d, want %0d", got.added, want.added));
        if (got.released !== want.released)
            report_mismatch($sformatf("pages released %0d, want %0d",
                                      got.released, want.released));
    endtask

endclass

module testbench;

    localparam int ADDR_W       = ffha_pkg::ADDR_W;
    localparam int STATUS_W     = ffha_pkg::STATUS_W;
    localparam int PAGES_W      = ffha_pkg::PAGES_W;
    localparam int REQ_W        = ffha_pkg::REQ_W;
    localparam int HEADER_BYTES = ffha_pkg::HEADER_BYTES;
    localparam int PAGE_BYTES   = ffha_pkg::PAGE_BYTES;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic [REQ_W-1:0] REQ_MAX = '1;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic                o_done;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [ADDR_W-1:0]   i_cfg_heap_base = '0;
    logic                i_cmd = 1'b0;
    logic [REQ_W-1:0]    i_request_size = '0;
    logic [ADDR_W-1:0]   i_user_address = '0;
    logic [ADDR_W-1:0]   o_result_address;
    logic [STATUS_W-1:0] o_status;
    logic [ADDR_W-1:0]   o_heap_end;
    logic [PAGES_W-1:0]  o_pages_added;
    logic [PAGES_W-1:0]  o_pages_released;

    heap_scoreboard sb = new();

    first_fit_heap_allocator_top u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .o_done           (o_done),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_heap_base  (i_cfg_heap_base),
        .i_cmd            (i_cmd),
        .i_request_size   (i_request_size),
        .i_user_address   (i_user_address),
        .o_result_address (o_result_address),
        .o_status         (o_status),
        .o_heap_end       (o_heap_end),
        .o_pages_added    (o_pages_added),
        .o_pages_released (o_pages_released)
    );

    always #5 i_clk = ~i_clk;

    // Monitor. All inputs change by nonblocking assignment at the edge, so the
    // values read here are the ones the block saw. A result beat shown in the
    // same cycle as a new command belongs to the older command, so it is
    // checked before the new command is noted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done)
                sb.check_result('{o_result_address, o_status, o_heap_end,
                                  o_pages_added, o_pages_released});
            if (start && !busy)
                sb.note_command(i_cmd, i_request_size, i_user_address);
            if (i_cfg_valid && o_cfg_ready)
                sb.set_base(i_cfg_heap_base);
        end
    end

    // Issues one command after a random gap. Start is left high on return so
    // that a following command with no gap keeps it high without a glitch.
    task automatic issue(logic cmd, logic [REQ_W-1:0] req, logic [ADDR_W-1:0] ua);
        int gap;
        gap = $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_cmd          <= cmd;
        i_request_size <= req;
        i_user_address <= ua;
        do @(posedge i_clk); while (busy);
    endtask

    // Waits until every outstanding result beat has arrived.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0 || busy) @(posedge i_clk);
    endtask

    // Writes heap_base while the block is idle.
    task automatic write_base(logic [ADDR_W-1:0] value);
        drain();
        repeat (4) @(posedge i_clk);
        i_cfg_valid     <= 1'b1;
        i_cfg_heap_base <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly small requests, some spanning pages, a few at the extreme.
    function automatic logic [REQ_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return REQ_W'($urandom_range(0, 255));
        if (r < 85) return REQ_W'($urandom_range(0, 3 * PAGE_BYTES));
        if (r < 95) return REQ_W'($urandom);
        return REQ_W'(REQ_MAX - $urandom_range(0, 20));
    endfunction

    // One random phase. alloc_pct sets the mix; frees mostly name live chunks.
    task automatic random_phase(int count, int alloc_pct);
        int r;
        for (int n = 0; n < count; n++) begin
            // Hold off once per phase until the block has fully drained.
            if (n == count / 2) drain();
            r = $urandom_range(0, 99);
            if (r < alloc_pct)
                issue(CMD_ALLOC, pick_size(), $urandom);
            else if (r < alloc_pct + (100 - alloc_pct) * 4 / 5)
                issue(ffha_pkg::CMD_FREE, REQ_W'($urandom), sb.live_address());
            else
                issue(ffha_pkg::CMD_FREE, REQ_W'($urandom), $urandom);
        end
    endtask

    initial begin
        logic [ADDR_W-1:0] first, second;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: smallest and largest requests, an unknown address, a
        // double free, and a merge that would overflow the length field.
        issue(CMD_ALLOC, '0, '0);
        issue(CMD_ALLOC, REQ_MAX, '1);
        issue(CMD_ALLOC, REQ_MAX, '0);
        issue(CMD_ALLOC, 24'd100, '0);
        drain();
        first  = sb.chunk_at[1] + HEADER_BYTES;
        second = sb.chunk_at[2] + HEADER_BYTES;
        issue(ffha_pkg::CMD_FREE, '0, first);
        issue(ffha_pkg::CMD_FREE, '1, second);
        issue(ffha_pkg::CMD_FREE, '0, first);
        issue(ffha_pkg::CMD_FREE, '0, '1);
        issue(ffha_pkg::CMD_FREE, '0, sb.chunk_at[0] + HEADER_BYTES);
        drain();
        issue(ffha_pkg::CMD_FREE, '0, sb.live_address());
        // A split hit, then the heap end at the top of the address space.
        issue(CMD_ALLOC, 24'd1000, '0);
        issue(CMD_ALLOC, 24'd1000, '0);
        drain();
        issue(ffha_pkg::CMD_FREE, '0, sb.chunk_at[0] + HEADER_BYTES);
        issue(CMD_ALLOC, 24'd10, '0);
        write_base(32'hFFFF_F000);
        issue(CMD_ALLOC, 24'd4000, '0);
        issue(CMD_ALLOC, 24'd200, '0);
        issue(CMD_ALLOC, REQ_MAX, '0);
        drain();
        issue(ffha_pkg::CMD_FREE, '0, sb.live_address());

        // Random phases across several heap bases; the alloc-heavy ones fill
        // the table so that appends fail and splits are refused.
        write_base('0);
        random_phase(300, 60);
        random_phase(200, 90);
        write_base(32'h7FFF_0000);
        random_phase(300, 55);
        write_base({20'($urandom_range(0, 32'hF_FFFF)), 12'h000});
        random_phase(300, 85);
        write_base(32'hFFF0_0000);
        random_phase(150, 60);
        write_base(32'hFFFF_F000);
        random_phase(100, 60);
        write_base(32'h0000_1000);
        random_phase(300, 65);

        drain();
        repeat (200) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
design/ffha_pkg.sv
design/ffha_ram.sv
design/ffha_dp.sv
design/ffha_ctrl.sv
design/first_fit_heap_allocator_top.sv
tb/testbench.sv
